@@ src/online_bin_packer_assert.svh @@
// Assertion macros used by the online bin packer checker.
`ifndef ONLINE_BIN_PACKER_ASSERT_SVH
`define ONLINE_BIN_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define OBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("online_bin_packer: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define OBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("online_bin_packer: next-cycle check failed");

`endif

@@ src/obp_pkg.sv @@
// Shared types, codes and defaults for the online bin packer.
package obp_pkg;

    localparam int DEF_MAX_BINS    = 64;
    localparam int DEF_WEIGHT_BITS = 24;

    localparam int CAP_BITS    = 24;
    localparam int IDX_OUT_W   = 6;
    localparam int USED_OUT_W  = 7;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 1'd1;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 24'd25600;

    // fit modes
    localparam logic FIT_NEXT  = 1'b0;
    localparam logic FIT_FIRST = 1'b1;
    localparam logic FIT_MODE_RESET = FIT_FIRST;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // control part of a request as it walks down the cell row
    typedef struct packed {
        logic valid;     // a request sits in this slot
        logic last;      // final request of a set
        logic done;      // already placed in, or opened, a bin
        logic oversize;  // weight above capacity
    } tok_flags_t;

endpackage

@@ src/online_bin_packer.sv @@
// Online bin packer top level: config registers, systolic row of bin cells, result port.
// One register per cell; the last cell's output register is the result register.
// Throughput: one request per cycle unless the result stalls; MAX_BINS cells hold that many in flight.
// The whole row advances together; a stalled result holds the row and the input.
// Reset (rst_n low, asynchronous) closes all bins, empties the row, and sets
// capacity to 100.0 and the mode to first fit. Bin loads need no clearing.
module online_bin_packer
    import obp_pkg::*;
#(
    parameter int MAX_BINS    = DEF_MAX_BINS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [WEIGHT_BITS-1:0] weight,
    input  logic                   last_item,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [IDX_OUT_W-1:0]   bin_index,
    output logic [USED_OUT_W-1:0]  bins_used,
    output logic [STATUS_W-1:0]    status
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CMP_W = ((WEIGHT_BITS > CAP_BITS) ? WEIGHT_BITS : CAP_BITS) + 1;

    logic [CAP_BITS-1:0] capacity_reg;
    logic                fit_mode_reg;
    logic                advance;

    // slot i feeds cell i; slot MAX_BINS is the result register
    tok_flags_t             tok_flags  [0:MAX_BINS];
    logic [WEIGHT_BITS-1:0] tok_weight [0:MAX_BINS];
    logic [IDX_W-1:0]       tok_idx    [0:MAX_BINS];
    logic [CNT_W-1:0]       tok_used   [0:MAX_BINS];
    // open state of each bin once the request now at it has passed
    logic                   open_after [0:MAX_BINS];

    // Configuration registers; the user must write them only while the row is empty. The block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            fit_mode_reg <= FIT_MODE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CAPACITY: capacity_reg <= cfg_data[CAP_BITS-1:0];
                REG_FIT_MODE: fit_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance the row whenever the result register is empty or being taken.
    assign advance  = ~out_valid | ~out_stall;
    assign in_stall = ~advance;

    // Build the entering request; flag an oversize weight once, up front.
    always_comb
    begin
        tok_flags[0].valid    = in_valid;
        tok_flags[0].last     = last_item;
        tok_flags[0].done     = 1'b0;
        tok_flags[0].oversize = CMP_W'(weight) > CMP_W'(capacity_reg);
        tok_weight[0] = weight;
        tok_idx[0]    = '0;
        tok_used[0]   = '0;
    end

    // The top bin has nothing above it, so it is the newest whenever open.
    assign open_after[MAX_BINS] = 1'b0;

    // Each cell tries the request against its own bin: it places the weight
    // if the bin fits (first fit: any open bin, next fit: only the newest),
    // opens itself if closed and the request is still unplaced, and hands
    // the request up. Bins open in order, so the open ones are a prefix.
    for (genvar i = 0; i < MAX_BINS; i++)
    begin : g_cell
        obp_cell #(
            .MAX_BINS    (MAX_BINS),
            .WEIGHT_BITS (WEIGHT_BITS),
            .INDEX       (i)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (advance),
            .capacity        (capacity_reg),
            .fit_mode        (fit_mode_reg),
            .in_flags        (tok_flags[i]),
            .in_weight       (tok_weight[i]),
            .in_idx          (tok_idx[i]),
            .in_used         (tok_used[i]),
            .next_open_after (open_after[i+1]),
            .open_after      (open_after[i]),
            .out_flags       (tok_flags[i+1]),
            .out_weight      (tok_weight[i+1]),
            .out_idx         (tok_idx[i+1]),
            .out_used        (tok_used[i+1])
        );
    end

    // Result register is the last cell's output slot. An unplaced request
    // found every bin open and full: drop it and report bin zero.
    assign out_valid = tok_flags[MAX_BINS].valid;
    assign bin_index = tok_flags[MAX_BINS].done ? IDX_OUT_W'(tok_idx[MAX_BINS])
                                                : '0;
    assign bins_used = USED_OUT_W'(tok_used[MAX_BINS]);
    assign status    = !tok_flags[MAX_BINS].done    ? ST_FULL     :
                       tok_flags[MAX_BINS].oversize ? ST_OVERSIZE : ST_PLACED;

endmodule

@@ src/obp_cell.sv @@
// One bin of the packer row: holds the bin load and open bit, forwards the request.
module obp_cell
    import obp_pkg::*;
#(
    parameter int MAX_BINS    = DEF_MAX_BINS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int INDEX       = 0
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [CAP_BITS-1:0]             capacity,
    input  logic                            fit_mode,
    input  tok_flags_t                      in_flags,
    input  logic [WEIGHT_BITS-1:0]          in_weight,
    input  logic [$clog2(MAX_BINS)-1:0]     in_idx,
    input  logic [$clog2(MAX_BINS+1)-1:0]   in_used,
    input  logic                            next_open_after,
    output logic                            open_after,
    output tok_flags_t                      out_flags,
    output logic [WEIGHT_BITS-1:0]          out_weight,
    output logic [$clog2(MAX_BINS)-1:0]     out_idx,
    output logic [$clog2(MAX_BINS+1)-1:0]   out_used
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CMP_W = ((WEIGHT_BITS > CAP_BITS) ? WEIGHT_BITS : CAP_BITS) + 1;

    logic                   open_reg;
    logic [WEIGHT_BITS-1:0] load_reg;
    logic [WEIGHT_BITS-1:0] load_next;
    tok_flags_t             flags_reg;
    tok_flags_t             flags_next;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [CNT_W-1:0]       used_reg;
    logic [CNT_W-1:0]       used_next;
    logic [CMP_W-1:0]       sum;
    logic                   live;
    logic                   fits;
    logic                   place;
    logic                   open_new;

    always_comb
    begin
        sum  = CMP_W'(load_reg) + CMP_W'(in_weight);
        live = in_flags.valid & ~in_flags.done;
        // next fit: this bin is the newest when the bin above stays closed
        fits = open_reg & ~in_flags.oversize & (sum <= CMP_W'(capacity))
               & ((fit_mode == FIT_FIRST) | ~next_open_after);
        place    = live & fits;
        open_new = live & ~open_reg;
        open_after = open_reg | open_new;

        load_next = load_reg;
        if (open_new)
        begin
            load_next = in_weight;
        end
        else if (place)
        begin
            load_next = sum[WEIGHT_BITS-1:0];
        end

        flags_next      = in_flags;
        flags_next.done = in_flags.done | place | open_new;
        idx_next  = (place | open_new) ? IDX_W'(INDEX) : in_idx;
        used_next = open_after ? CNT_W'(INDEX + 1) : in_used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
            if (in_flags.valid)
            begin
                // a last request closes the bin behind it
                open_reg <= in_flags.last ? 1'b0 : open_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            weight_reg <= in_weight;
            idx_reg    <= idx_next;
            used_reg   <= used_next;
            if (in_flags.valid)
            begin
                load_reg <= load_next;
            end
        end
    end

    assign out_flags  = flags_reg;
    assign out_weight = weight_reg;
    assign out_idx    = idx_reg;
    assign out_used   = used_reg;

endmodule

@@ src/obp_checker.sv @@
// Port-level checker for the online bin packer, bound to the top level.
`include "online_bin_packer_assert.svh"

module obp_checker
    import obp_pkg::*;
#(
    parameter int MAX_BINS    = DEF_MAX_BINS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_write,
    input logic [CFG_IDX_W-1:0]   cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [WEIGHT_BITS-1:0] weight,
    input logic                   last_item,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [IDX_OUT_W-1:0]   bin_index,
    input logic [USED_OUT_W-1:0]  bins_used,
    input logic [STATUS_W-1:0]    status
);

    localparam logic [USED_OUT_W-1:0] FULL_COUNT = USED_OUT_W'(MAX_BINS);

    // status carries only the three defined codes
    `OBP_ASSERT_SAME(a_status_code, out_valid, (status == ST_PLACED) || (status == ST_OVERSIZE) || (status == ST_FULL))

    // a dropped request reports bin zero and every bin in use
    `OBP_ASSERT_SAME(a_drop_form, out_valid && (status == ST_FULL), (bin_index == '0) && (bins_used == FULL_COUNT))

    // a draining result never holds off the input
    `OBP_ASSERT_SAME(a_no_idle_stall, !out_valid || !out_stall, !in_stall)

    // a stalled result holds
    `OBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bin_index) && $stable(bins_used) && $stable(status))

endmodule

bind online_bin_packer obp_checker #(
    .MAX_BINS    (MAX_BINS),
    .WEIGHT_BITS (WEIGHT_BITS)
) u_obp_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the online bin packer: directed and random request streams.
module testbench;
    import obp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BIN_COUNT     = DEF_MAX_BINS;
    localparam int WEIGHT_W      = DEF_WEIGHT_BITS;
    localparam int RANDOM_TARGET = 1400;   // random requests to offer
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam longint TIMEOUT_NS = 2_000_000;
    localparam logic [CAP_BITS-1:0] CAP_MAX = {CAP_BITS{1'b1}};

    // One expected result: where a request landed and what the table looked like after.
    typedef struct packed {
        logic [IDX_OUT_W-1:0]  bin_index;
        logic [USED_OUT_W-1:0] bins_used;
        logic [STATUS_W-1:0]   status;
    } placement_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [WEIGHT_W-1:0]    weight;
    logic                   last_item;
    logic                   out_valid;
    logic                   out_stall;
    logic [IDX_OUT_W-1:0]   bin_index;
    logic [USED_OUT_W-1:0]  bins_used;
    logic [STATUS_W-1:0]    status;

    // Packing state as the block should hold it, plus the register copies.
    logic [WEIGHT_W-1:0]    bin_fill [BIN_COUNT];
    int                     bins_open;
    int                     last_opened;
    logic [CAP_BITS-1:0]    cap_setting  = CAPACITY_RESET;
    logic                   mode_setting = FIT_MODE_RESET;

    placement_t             placements [$];   // results still owed by the block

    // Traffic shaping shared between the test tasks and the receiver.
    int gap_pct    = 25;   // chance in a hundred that the sender idles a cycle
    int stall_pct  = 25;   // chance in a hundred that the receiver stalls a cycle
    int hold_armed = 0;    // bumped by a test to ask for a long hold-off
    int hold_taken = 0;
    int hold_left  = 0;

    int mismatch_count  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int oversize_seen   = 0;
    int full_seen       = 0;
    int settings_used   = 1;

    online_bin_packer #(
        .MAX_BINS    (BIN_COUNT),
        .WEIGHT_BITS (WEIGHT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .weight    (weight),
        .last_item (last_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bin_index (bin_index),
        .bins_used (bins_used),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: no correct run comes anywhere near this.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout after %0d ns with %0d results outstanding",
                 TIMEOUT_NS, placements.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Place one request into the mirrored table and queue the result it must produce.
    // First fit walks the open bins from 0 upward; next fit only tries the newest bin.
    // The sums are taken one bit wider so a full-scale load plus weight cannot wrap.
    function automatic void pack_weight(input logic [WEIGHT_W-1:0] w, input logic last);
        placement_t res;
        logic       found;
        int         slot;
        res.status = ST_PLACED;
        found      = 1'b0;
        slot       = 0;
        if (w > cap_setting)
            res.status = ST_OVERSIZE;
        else if (mode_setting == FIT_FIRST)
        begin
            for (int b = 0; b < bins_open; b++)
            begin
                if (!found && ({1'b0, bin_fill[b]} + w <= cap_setting))
                begin
                    slot  = b;
                    found = 1'b1;
                end
            end
        end
        else if (bins_open > 0 && ({1'b0, bin_fill[last_opened]} + w <= cap_setting))
        begin
            slot  = last_opened;
            found = 1'b1;
        end

        if (found)
            bin_fill[slot] = bin_fill[slot] + w;
        else if (bins_open < BIN_COUNT)
        begin
            // open a fresh bin; an oversize weight lands here too
            slot           = bins_open;
            bin_fill[slot] = w;
            last_opened    = slot;
            bins_open++;
        end
        else
        begin
            // table full: drop, state untouched
            slot       = 0;
            res.status = ST_FULL;
        end

        res.bin_index = slot[IDX_OUT_W-1:0];
        res.bins_used = bins_open[USED_OUT_W-1:0];
        placements.push_back(res);

        // end of set: close every bin, keep the registers
        if (last)
        begin
            bins_open   = 0;
            last_opened = 0;
        end
    endfunction

    // Offer one request. Call at a rising edge; returns at the edge where it was taken.
    // Idle cycles are inserted up front so valid never drops while a request is pending.
    task automatic send_request(input logic [WEIGHT_W-1:0] w, input logic last);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        in_valid  <= 1'b1;
        weight    <= w;
        last_item <= last;
        do
            @(posedge clk);
        while (in_stall);
        pack_weight(w, last);
        requests_sent++;
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic await_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (placements.size() != 0);
    endtask

    // Write both registers back to back on an idle block, then update the mirror.
    task automatic configure(input logic [CAP_BITS-1:0] cap, input logic mode);
        logic [CFG_DATA_W-2:0] junk;
        junk = (CFG_DATA_W-1)'($urandom);
        await_all_results();
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_data  <= cap;
        @(posedge clk);
        // upper bits of the mode write must be ignored by the block
        cfg_index <= REG_FIT_MODE;
        cfg_data  <= {junk, mode};
        @(posedge clk);
        cfg_write <= 1'b0;
        cap_setting  = cap;
        mode_setting = mode;
        settings_used++;
    endtask

    // Draw a weight around the current capacity. Style sets how many items share a bin:
    // 0 many small ones, 1 a few, 2 one or two per bin so the table fills.
    function automatic logic [WEIGHT_W-1:0] pick_weight(input logic [CAP_BITS-1:0] cap,
                                                        input int style);
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return WEIGHT_W'($urandom);
        if (roll < 12)
        begin
            if (cap == CAP_MAX)
                return cap;
            span = 32'(CAP_MAX) - 32'(cap);
            return WEIGHT_W'(32'(cap) + 1 + ($urandom % span));
        end
        if (roll < 16)
            return ($urandom_range(0, 1) != 0) ? cap : '0;
        case (style)
            0:       return WEIGHT_W'($urandom_range(0, cap / 8));
            1:       return WEIGHT_W'($urandom_range(0, cap / 2));
            default: return WEIGHT_W'($urandom_range(cap / 2, cap));
        endcase
    endfunction

    // Receiver: random stalls, or a counted hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed != hold_taken)
        begin
            hold_taken <= hold_armed;
            hold_left  <= HOLD_CYCLES - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result checker: compare every accepted result with the oldest one owed.
    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (placements.size() == 0)
                flag_mismatch($sformatf("result with nothing outstanding: bin %0d used %0d st %0d",
                                        bin_index, bins_used, status));
            else
            begin
                want = placements.pop_front();
                if (bin_index !== want.bin_index)
                    flag_mismatch($sformatf("result %0d bin_index got %0d want %0d",
                                            results_checked, bin_index, want.bin_index));
                if (bins_used !== want.bins_used)
                    flag_mismatch($sformatf("result %0d bins_used got %0d want %0d",
                                            results_checked, bins_used, want.bins_used));
                if (status !== want.status)
                    flag_mismatch($sformatf("result %0d status got %0d want %0d",
                                            results_checked, status, want.status));
                if (want.status == ST_OVERSIZE)
                    oversize_seen++;
                if (want.status == ST_FULL)
                    full_seen++;
                results_checked++;
            end
        end
    end

    // Reset values: exact fits, oversize at the edge and at full scale, zero weights.
    task automatic test_reset_defaults();
        send_request(24'd0, 1'b0);
        send_request(24'd25600, 1'b0);
        send_request(24'd1, 1'b0);
        send_request(24'd25599, 1'b0);
        send_request(24'd25601, 1'b0);
        send_request(CAP_MAX, 1'b0);
        send_request(24'd0, 1'b0);
        send_request(24'd12800, 1'b0);
        send_request(24'd12800, 1'b1);
    endtask

    // Next fit: start with no open bin, skip older bins with room, oversize as newest.
    task automatic test_next_fit();
        configure(24'd1000, FIT_NEXT);
        send_request(24'd600, 1'b0);
        send_request(24'd600, 1'b0);
        send_request(24'd300, 1'b0);
        send_request(24'd400, 1'b0);
        send_request(24'd300, 1'b0);
        send_request(24'd1001, 1'b0);
        send_request(24'd0, 1'b1);
    endtask

    // Full-scale capacity: loads reach the top of the range without wrapping.
    task automatic test_capacity_extremes();
        configure(CAP_MAX, FIT_FIRST);
        send_request(CAP_MAX, 1'b0);
        send_request(24'd1, 1'b0);
        send_request(CAP_MAX - 24'd1, 1'b0);
        send_request(CAP_MAX, 1'b0);
        send_request(24'd0, 1'b1);
    endtask

    // Both modes: fill every bin at capacity one, then drop fitting requests (and, under first fit, an oversize one).
    task automatic test_table_full();
        configure(24'd1, FIT_FIRST);
        repeat (BIN_COUNT) send_request(24'd1, 1'b0);
        send_request(24'd1, 1'b0);
        send_request(24'd2, 1'b0);
        send_request(24'd0, 1'b1);
        configure(24'd1, FIT_NEXT);
        repeat (BIN_COUNT) send_request(24'd1, 1'b0);
        send_request(24'd1, 1'b0);
        send_request(24'd0, 1'b1);
    endtask

    // Hold the result side long enough that the row fills and the input stalls,
    // while the sender keeps offering back to back.
    task automatic test_backpressure();
        configure(CAPACITY_RESET, FIT_FIRST);
        gap_pct   = 0;
        stall_pct = 0;
        hold_armed++;
        for (int k = 0; k < 150; k++)
            send_request(pick_weight(cap_setting, 1), k == 149);
        gap_pct   = 25;
        stall_pct = 25;
    endtask

    // Pause the sender mid-set until the block has returned everything, then continue.
    task automatic test_sender_pause();
        configure(24'd5000, FIT_FIRST);
        repeat (20) send_request(pick_weight(cap_setting, 1), 1'b0);
        await_all_results();
        for (int k = 0; k < 20; k++)
            send_request(pick_weight(cap_setting, 1), k == 19);
    endtask

    // Random sets under a new setting per phase. Most sets are well formed with a
    // closing last item; a few close early or run on into the next set.
    task automatic test_random_sets();
        int                  phase;
        int                  start;
        int                  len;
        int                  style;
        int                  roll;
        logic                cut;
        logic [CAP_BITS-1:0] cap;
        logic                mode;
        phase = 0;
        start = requests_sent;
        while (requests_sent - start < RANDOM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (phase == 0 || roll < 8)
                cap = CAP_MAX;
            else if (phase == 1 || roll < 16)
                cap = 24'd1;
            else if (roll < 30)
                cap = CAP_BITS'($urandom_range(2, 16));
            else if (roll < 45)
                cap = CAP_BITS'($urandom);
            else
                cap = CAP_BITS'($urandom_range(16, 65535));
            mode = ($urandom_range(0, 1) != 0) ? FIT_FIRST : FIT_NEXT;
            configure(cap, mode);

            // one long stretch with no idling on either side
            gap_pct   = (phase == 3) ? 0 : 25;
            stall_pct = (phase == 3) ? 0 : 25;

            repeat ($urandom_range(2, 5))
            begin
                len   = $urandom_range(1, 100);
                style = $urandom_range(0, 2);
                cut   = ($urandom_range(0, 99) < 10);   // run on without a last item
                for (int k = 0; k < len; k++)
                    send_request(pick_weight(cap, style),
                                 (k == len - 1 && !cut) || $urandom_range(0, 99) < 2);
            end
            phase++;
        end
        gap_pct   = 25;
        stall_pct = 25;
    endtask

    initial
    begin
        // Hold every input at a known value while reset is low.
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_CAPACITY;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        weight    <= '0;
        last_item <= 1'b0;
        out_stall <= 1'b0;
        bins_open   = 0;
        last_opened = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_next_fit();
        test_capacity_extremes();
        test_table_full();
        test_backpressure();
        test_sender_pause();
        test_random_sets();

        // Drain, then give the row time to show any stray result.
        await_all_results();
        repeat (BIN_COUNT + 8) @(posedge clk);

        $display("Covered %0d requests and %0d results over %0d register settings,",
                 requests_sent, results_checked, settings_used);
        $display("both fit modes, with %0d oversize and %0d table-full results.",
                 oversize_seen, full_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
